// ===== rtl/core/dcs_pkg.sv =====
// Shared types, constants and fixed-point helpers of the distance constraint solver.
package dcs_pkg;

   localparam int Q_FRAC     = 16;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 48;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [65:0] W_MAX   = 66'sd2147483647;
   localparam logic signed [65:0] W_MIN   = -66'sd2147483648;
   localparam logic signed [65:0] W_ROUND = 66'sd65535;

   localparam logic [30:0] LINK_RESET = 31'd65536;
   localparam logic [63:0] ROOT_BIT0  = 64'h4000_0000_0000_0000;
   localparam logic [47:0] EFF_NUM    = 48'h0001_0000_0000;
   localparam logic [63:0] LEN_MAX    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [47:0] EFF_MAX    = 48'h0000_7FFF_FFFF;

   typedef enum logic [0:0] {
      CSR_LINK_LENGTH = 1'b0,
      CSR_CABLE_MODE  = 1'b1
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL_A = 6'b000010,
      ST_MUL_B = 6'b000100,
      ST_ROOT  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef enum logic [4:0] {
      S_DXX, S_DYY, S_JVX, S_JVY, S_LAM, S_PX, S_PY,
      S_VAX, S_VBX, S_VAY, S_VBY, S_TX, S_EX, S_TY, S_EY,
      S_PAX, S_PBX, S_PAY, S_PBY
   } step_type;

   typedef enum logic [1:0] {
      DV_DIRX,
      DV_DIRY,
      DV_EFF
   } div_sel_type;

   function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
      return {a[31], a};
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? S32_MIN : S32_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat33(sx33(a) + sx33(b));
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat33(sx33(a) - sx33(b));
   endfunction

   // Drop the fraction of a product, truncating toward zero, then saturate.
   function automatic logic signed [31:0] qpost(input logic signed [65:0] p);
      logic signed [65:0] adj;
      logic signed [65:0] sh;
      logic signed [31:0] r;
      adj = p + (p[65] ? W_ROUND : 66'sd0);
      sh  = adj >>> Q_FRAC;
      if (sh > W_MAX) begin
         r = S32_MAX;
      end else if (sh < W_MIN) begin
         r = S32_MIN;
      end else begin
         r = sh[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/distance_constraint_solver_top.sv =====
// Distance constraint solver: sequencer around one shared multiplier, root and divider.
// When the link acts, an item runs two squares, a bit-pair square root, three restoring
// divisions of 48 steps each and seventeen multiply steps. A slack cable returns right
// after the root, without the divisions or the multiply steps.
// One item at a time: the next transfer is taken once the result has been taken.
// Synchronous active-high reset clears the sequencer and the accumulated impulse and
// loads link_length 1.0 and rod mode.
module distance_constraint_solver_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_a_x,
   input  logic signed [31:0] req_pos_a_y,
   input  logic signed [31:0] req_pos_b_x,
   input  logic signed [31:0] req_pos_b_y,
   input  logic signed [31:0] req_vel_a_x,
   input  logic signed [31:0] req_vel_a_y,
   input  logic signed [31:0] req_vel_b_x,
   input  logic signed [31:0] req_vel_b_y,
   input  logic [30:0]        req_inv_mass_a,
   input  logic [30:0]        req_inv_mass_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_pos_a_x,
   output logic signed [31:0] rsp_new_pos_a_y,
   output logic signed [31:0] rsp_new_pos_b_x,
   output logic signed [31:0] rsp_new_pos_b_y,
   output logic signed [31:0] rsp_new_vel_a_x,
   output logic signed [31:0] rsp_new_vel_a_y,
   output logic signed [31:0] rsp_new_vel_b_x,
   output logic signed [31:0] rsp_new_vel_b_y,
   output logic signed [31:0] rsp_total_impulse,
   output logic               rsp_acted
);

   dcs_pkg::state_type   state_ff, state_in;
   dcs_pkg::step_type    step_ff, step_in;
   dcs_pkg::div_sel_type sel_ff, sel_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic signed [31:0]   sum_ff, sum_in;
   logic [30:0]          link_ff, link_in;
   logic                 cable_ff, cable_in;

   logic signed [31:0] pax_ff, pax_in, pay_ff, pay_in, pbx_ff, pbx_in, pby_ff, pby_in;
   logic signed [31:0] vax_ff, vax_in, vay_ff, vay_in, vbx_ff, vbx_in, vby_ff, vby_in;
   logic [30:0]        ima_ff, ima_in, imb_ff, imb_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, rvx_ff, rvx_in, rvy_ff, rvy_in;
   logic signed [31:0] len_ff, len_in, err_ff, err_in;
   logic signed [31:0] dirx_ff, dirx_in, diry_ff, diry_in, eff_ff, eff_in;
   logic signed [31:0] jv_ff, jv_in, lam_ff, lam_in, px_ff, px_in, py_ff, py_in;
   logic signed [31:0] t_ff, t_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [65:0] acc_ff, acc_in, prod_ff, prod_in;
   logic [63:0]        rt_n_ff, rt_n_in, rt_r_ff, rt_r_in, rt_bit_ff, rt_bit_in;
   logic [47:0]        dv_q_ff, dv_q_in;
   logic [31:0]        dv_rem_ff, dv_rem_in, dvsr_ff, dvsr_in;

   logic signed [31:0] npax_ff, npax_in, npay_ff, npay_in, npbx_ff, npbx_in;
   logic signed [31:0] npby_ff, npby_in, nvax_ff, nvax_in, nvay_ff, nvay_in;
   logic signed [31:0] nvbx_ff, nvbx_in, nvby_ff, nvby_in, total_ff, total_in;
   logic               acted_ff, acted_in;

   logic signed [32:0] opa, opb;
   logic signed [31:0] qm;
   logic signed [65:0] accs;
   logic [63:0]        rt_sum;
   logic [32:0]        rem_sh;
   logic               rem_ge;
   logic [31:0]        msum, mag_dx, mag_dy;
   logic [31:0]        len_c;
   logic signed [31:0] err_c;
   logic               ld;
   dcs_pkg::div_sel_type ld_sel;

   assign msum   = 32'(ima_ff) + 32'(imb_ff);
   assign mag_dx = dx_ff[31] ? 32'(-dx_ff) : dx_ff;
   assign mag_dy = dy_ff[31] ? 32'(-dy_ff) : dy_ff;
   assign qm     = dcs_pkg::qpost(prod_ff);
   assign accs   = acc_ff + prod_ff;
   assign rt_sum = rt_r_ff + rt_bit_ff;
   assign rem_sh = {dv_rem_ff, dv_q_ff[47]};
   assign rem_ge = rem_sh >= {1'b0, dvsr_ff};
   assign len_c  = (rt_r_ff > dcs_pkg::LEN_MAX) ? dcs_pkg::LEN_MAX[31:0] : rt_r_ff[31:0];
   assign err_c  = $signed({1'b0, len_c[30:0]}) - $signed({1'b0, link_ff});

   // Operand select of the shared multiplier.
   always_comb begin
      opa = dcs_pkg::sx33(dx_ff);
      opb = dcs_pkg::sx33(dx_ff);
      case (step_ff)
         dcs_pkg::S_DXX: begin opa = dcs_pkg::sx33(dx_ff);   opb = dcs_pkg::sx33(dx_ff); end
         dcs_pkg::S_DYY: begin opa = dcs_pkg::sx33(dy_ff);   opb = dcs_pkg::sx33(dy_ff); end
         dcs_pkg::S_JVX: begin opa = dcs_pkg::sx33(dirx_ff); opb = dcs_pkg::sx33(rvx_ff); end
         dcs_pkg::S_JVY: begin opa = dcs_pkg::sx33(diry_ff); opb = dcs_pkg::sx33(rvy_ff); end
         dcs_pkg::S_LAM: begin opa = dcs_pkg::sx33(eff_ff);  opb = -dcs_pkg::sx33(jv_ff); end
         dcs_pkg::S_PX:  begin opa = dcs_pkg::sx33(dirx_ff); opb = dcs_pkg::sx33(lam_ff); end
         dcs_pkg::S_PY:  begin opa = dcs_pkg::sx33(diry_ff); opb = dcs_pkg::sx33(lam_ff); end
         dcs_pkg::S_VAX: begin opa = dcs_pkg::sx33(px_ff);   opb = $signed({2'b00, ima_ff}); end
         dcs_pkg::S_VBX: begin opa = dcs_pkg::sx33(px_ff);   opb = $signed({2'b00, imb_ff}); end
         dcs_pkg::S_VAY: begin opa = dcs_pkg::sx33(py_ff);   opb = $signed({2'b00, ima_ff}); end
         dcs_pkg::S_VBY: begin opa = dcs_pkg::sx33(py_ff);   opb = $signed({2'b00, imb_ff}); end
         dcs_pkg::S_TX:  begin opa = -dcs_pkg::sx33(dirx_ff); opb = dcs_pkg::sx33(err_ff); end
         dcs_pkg::S_EX:  begin opa = dcs_pkg::sx33(t_ff);    opb = dcs_pkg::sx33(eff_ff); end
         dcs_pkg::S_TY:  begin opa = -dcs_pkg::sx33(diry_ff); opb = dcs_pkg::sx33(err_ff); end
         dcs_pkg::S_EY:  begin opa = dcs_pkg::sx33(t_ff);    opb = dcs_pkg::sx33(eff_ff); end
         dcs_pkg::S_PAX: begin opa = dcs_pkg::sx33(ex_ff);   opb = $signed({2'b00, ima_ff}); end
         dcs_pkg::S_PBX: begin opa = dcs_pkg::sx33(ex_ff);   opb = $signed({2'b00, imb_ff}); end
         dcs_pkg::S_PAY: begin opa = dcs_pkg::sx33(ey_ff);   opb = $signed({2'b00, ima_ff}); end
         dcs_pkg::S_PBY: begin opa = dcs_pkg::sx33(ey_ff);   opb = $signed({2'b00, imb_ff}); end
         default:        begin opa = dcs_pkg::sx33(dx_ff);   opb = dcs_pkg::sx33(dx_ff); end
      endcase
   end

   always_comb begin
      state_in = state_ff;  step_in = step_ff;  sel_in = sel_ff;  cnt_in = cnt_ff;
      sum_in = sum_ff;  link_in = link_ff;  cable_in = cable_ff;
      pax_in = pax_ff;  pay_in = pay_ff;  pbx_in = pbx_ff;  pby_in = pby_ff;
      vax_in = vax_ff;  vay_in = vay_ff;  vbx_in = vbx_ff;  vby_in = vby_ff;
      ima_in = ima_ff;  imb_in = imb_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  rvx_in = rvx_ff;  rvy_in = rvy_ff;
      len_in = len_ff;  err_in = err_ff;  dirx_in = dirx_ff;  diry_in = diry_ff;
      eff_in = eff_ff;  jv_in = jv_ff;  lam_in = lam_ff;  px_in = px_ff;  py_in = py_ff;
      t_in = t_ff;  ex_in = ex_ff;  ey_in = ey_ff;  acc_in = acc_ff;  prod_in = prod_ff;
      rt_n_in = rt_n_ff;  rt_r_in = rt_r_ff;  rt_bit_in = rt_bit_ff;
      dv_q_in = dv_q_ff;  dv_rem_in = dv_rem_ff;  dvsr_in = dvsr_ff;
      npax_in = npax_ff;  npay_in = npay_ff;  npbx_in = npbx_ff;  npby_in = npby_ff;
      nvax_in = nvax_ff;  nvay_in = nvay_ff;  nvbx_in = nvbx_ff;  nvby_in = nvby_ff;
      total_in = total_ff;  acted_in = acted_ff;
      ld = 1'b0;
      ld_sel = dcs_pkg::DV_DIRX;

      if (csr_wr_en) begin
         case (csr_index)
            dcs_pkg::CSR_LINK_LENGTH: link_in = csr_wdata;
            dcs_pkg::CSR_CABLE_MODE:  cable_in = csr_wdata[0];
            default:                  link_in = link_ff;
         endcase
      end

      case (state_ff)
         dcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               pax_in = req_pos_a_x;  pay_in = req_pos_a_y;
               pbx_in = req_pos_b_x;  pby_in = req_pos_b_y;
               vax_in = req_vel_a_x;  vay_in = req_vel_a_y;
               vbx_in = req_vel_b_x;  vby_in = req_vel_b_y;
               ima_in = req_inv_mass_a;  imb_in = req_inv_mass_b;
               dx_in  = dcs_pkg::sat_sub(req_pos_b_x, req_pos_a_x);
               dy_in  = dcs_pkg::sat_sub(req_pos_b_y, req_pos_a_y);
               rvx_in = dcs_pkg::sat_sub(req_vel_b_x, req_vel_a_x);
               rvy_in = dcs_pkg::sat_sub(req_vel_b_y, req_vel_a_y);
               step_in  = dcs_pkg::S_DXX;
               state_in = dcs_pkg::ST_MUL_A;
            end
         end
         dcs_pkg::ST_MUL_A: begin
            prod_in  = opa * opb;
            state_in = dcs_pkg::ST_MUL_B;
         end
         dcs_pkg::ST_MUL_B: begin
            state_in = dcs_pkg::ST_MUL_A;
            step_in  = dcs_pkg::step_type'(step_ff + 5'd1);
            case (step_ff)
               dcs_pkg::S_DXX: acc_in = prod_ff;
               dcs_pkg::S_DYY: begin
                  rt_n_in   = accs[63:0];
                  rt_r_in   = '0;
                  rt_bit_in = dcs_pkg::ROOT_BIT0;
                  cnt_in    = '0;
                  state_in  = dcs_pkg::ST_ROOT;
               end
               dcs_pkg::S_JVX: acc_in = prod_ff;
               dcs_pkg::S_JVY: jv_in = dcs_pkg::qpost(accs);
               dcs_pkg::S_LAM: begin
                  lam_in = qm;
                  sum_in = dcs_pkg::sat_add(sum_ff, qm);
               end
               dcs_pkg::S_PX:  px_in = qm;
               dcs_pkg::S_PY:  py_in = qm;
               dcs_pkg::S_VAX: nvax_in = dcs_pkg::sat_sub(vax_ff, qm);
               dcs_pkg::S_VBX: nvbx_in = dcs_pkg::sat_add(vbx_ff, qm);
               dcs_pkg::S_VAY: nvay_in = dcs_pkg::sat_sub(vay_ff, qm);
               dcs_pkg::S_VBY: nvby_in = dcs_pkg::sat_add(vby_ff, qm);
               dcs_pkg::S_TX:  t_in = qm;
               dcs_pkg::S_EX:  ex_in = qm;
               dcs_pkg::S_TY:  t_in = qm;
               dcs_pkg::S_EY:  ey_in = qm;
               dcs_pkg::S_PAX: npax_in = dcs_pkg::sat_sub(pax_ff, qm);
               dcs_pkg::S_PBX: npbx_in = dcs_pkg::sat_add(pbx_ff, qm);
               dcs_pkg::S_PAY: npay_in = dcs_pkg::sat_sub(pay_ff, qm);
               dcs_pkg::S_PBY: begin
                  npby_in  = dcs_pkg::sat_add(pby_ff, qm);
                  total_in = sum_ff;
                  acted_in = 1'b1;
                  state_in = dcs_pkg::ST_DONE;
               end
               default: acc_in = acc_ff;
            endcase
         end
         dcs_pkg::ST_ROOT: begin
            if (cnt_ff != 6'(dcs_pkg::ROOT_STEPS)) begin
               if (rt_n_ff >= rt_sum) begin
                  rt_n_in = rt_n_ff - rt_sum;
                  rt_r_in = (rt_r_ff >> 1) + rt_bit_ff;
               end else begin
                  rt_r_in = rt_r_ff >> 1;
               end
               rt_bit_in = rt_bit_ff >> 2;
               cnt_in    = cnt_ff + 6'd1;
            end else begin
               len_in = len_c;
               err_in = err_c;
               if (cable_ff && (err_c <= 32'sd0)) begin
                  // slack cable: pass the item through
                  npax_in = pax_ff;  npay_in = pay_ff;  npbx_in = pbx_ff;  npby_in = pby_ff;
                  nvax_in = vax_ff;  nvay_in = vay_ff;  nvbx_in = vbx_ff;  nvby_in = vby_ff;
                  total_in = sum_ff;
                  acted_in = 1'b0;
                  state_in = dcs_pkg::ST_DONE;
               end else begin
                  ld       = 1'b1;
                  ld_sel   = dcs_pkg::DV_DIRX;
                  state_in = dcs_pkg::ST_DIV;
               end
            end
         end
         dcs_pkg::ST_DIV: begin
            if (cnt_ff != 6'(dcs_pkg::DIV_STEPS)) begin
               dv_rem_in = rem_ge ? 32'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[31:0];
               dv_q_in   = {dv_q_ff[46:0], rem_ge};
               cnt_in    = cnt_ff + 6'd1;
            end else begin
               case (sel_ff)
                  dcs_pkg::DV_DIRX: begin
                     if (len_ff == 32'sd0) begin
                        dirx_in = '0;
                     end else begin
                        dirx_in = dx_ff[31] ? -$signed(dv_q_ff[31:0]) : $signed(dv_q_ff[31:0]);
                     end
                     ld     = 1'b1;
                     ld_sel = dcs_pkg::DV_DIRY;
                  end
                  dcs_pkg::DV_DIRY: begin
                     if (len_ff == 32'sd0) begin
                        diry_in = '0;
                     end else begin
                        diry_in = dy_ff[31] ? -$signed(dv_q_ff[31:0]) : $signed(dv_q_ff[31:0]);
                     end
                     ld     = 1'b1;
                     ld_sel = dcs_pkg::DV_EFF;
                  end
                  dcs_pkg::DV_EFF: begin
                     if (msum == 32'd0) begin
                        eff_in = '0;
                     end else if (dv_q_ff > dcs_pkg::EFF_MAX) begin
                        eff_in = dcs_pkg::S32_MAX;
                     end else begin
                        eff_in = $signed(dv_q_ff[31:0]);
                     end
                     step_in  = dcs_pkg::S_JVX;
                     state_in = dcs_pkg::ST_MUL_A;
                  end
                  default: state_in = dcs_pkg::ST_IDLE;
               endcase
            end
         end
         dcs_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = dcs_pkg::ST_IDLE;
            end
         end
         default: state_in = dcs_pkg::ST_IDLE;
      endcase

      // load the divider for the next quotient
      if (ld) begin
         sel_in    = ld_sel;
         cnt_in    = '0;
         dv_rem_in = '0;
         case (ld_sel)
            dcs_pkg::DV_DIRX: begin dv_q_in = {mag_dx, 16'd0}; dvsr_in = len_in; end
            dcs_pkg::DV_DIRY: begin dv_q_in = {mag_dy, 16'd0}; dvsr_in = len_in; end
            dcs_pkg::DV_EFF:  begin dv_q_in = dcs_pkg::EFF_NUM; dvsr_in = msum; end
            default:          begin dv_q_in = dcs_pkg::EFF_NUM; dvsr_in = msum; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcs_pkg::ST_IDLE;
         step_ff  <= dcs_pkg::S_DXX;
         sel_ff   <= dcs_pkg::DV_DIRX;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         link_ff  <= dcs_pkg::LINK_RESET;
         cable_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         link_ff  <= link_in;
         cable_ff <= cable_in;
      end
   end

   always_ff @(posedge clock) begin
      pax_ff <= pax_in;  pay_ff <= pay_in;  pbx_ff <= pbx_in;  pby_ff <= pby_in;
      vax_ff <= vax_in;  vay_ff <= vay_in;  vbx_ff <= vbx_in;  vby_ff <= vby_in;
      ima_ff <= ima_in;  imb_ff <= imb_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  rvx_ff <= rvx_in;  rvy_ff <= rvy_in;
      len_ff <= len_in;  err_ff <= err_in;  dirx_ff <= dirx_in;  diry_ff <= diry_in;
      eff_ff <= eff_in;  jv_ff <= jv_in;  lam_ff <= lam_in;  px_ff <= px_in;  py_ff <= py_in;
      t_ff <= t_in;  ex_ff <= ex_in;  ey_ff <= ey_in;  acc_ff <= acc_in;  prod_ff <= prod_in;
      rt_n_ff <= rt_n_in;  rt_r_ff <= rt_r_in;  rt_bit_ff <= rt_bit_in;
      dv_q_ff <= dv_q_in;  dv_rem_ff <= dv_rem_in;  dvsr_ff <= dvsr_in;
      npax_ff <= npax_in;  npay_ff <= npay_in;  npbx_ff <= npbx_in;  npby_ff <= npby_in;
      nvax_ff <= nvax_in;  nvay_ff <= nvay_in;  nvbx_ff <= nvbx_in;  nvby_ff <= nvby_in;
      total_ff <= total_in;  acted_ff <= acted_in;
   end

   assign req_stall         = (state_ff != dcs_pkg::ST_IDLE);
   assign rsp_valid         = (state_ff == dcs_pkg::ST_DONE);
   assign rsp_new_pos_a_x   = npax_ff;
   assign rsp_new_pos_a_y   = npay_ff;
   assign rsp_new_pos_b_x   = npbx_ff;
   assign rsp_new_pos_b_y   = npby_ff;
   assign rsp_new_vel_a_x   = nvax_ff;
   assign rsp_new_vel_a_y   = nvay_ff;
   assign rsp_new_vel_b_x   = nvbx_ff;
   assign rsp_new_vel_b_y   = nvby_ff;
   assign rsp_total_impulse = total_ff;
   assign rsp_acted         = acted_ff;

endmodule

// ===== bench/distance_constraint_solver_top_test.sv =====
// Self-checking bench for the distance constraint solver: directed links, random links, stalls.
`timescale 1ns / 100ps

module distance_constraint_solver_top_test;

   typedef struct {
      logic signed [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
      logic [30:0]        ima, imb;
   } link_item_type;

   typedef struct {
      logic signed [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby, imp;
      logic               acted;
   } link_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [0:0]         csr_index = dcs_pkg::CSR_LINK_LENGTH;
   logic [30:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_a_x = '0, req_pos_a_y = '0, req_pos_b_x = '0, req_pos_b_y = '0;
   logic signed [31:0] req_vel_a_x = '0, req_vel_a_y = '0, req_vel_b_x = '0, req_vel_b_y = '0;
   logic [30:0]        req_inv_mass_a = '0, req_inv_mass_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [31:0] rsp_new_pos_a_x, rsp_new_pos_a_y, rsp_new_pos_b_x, rsp_new_pos_b_y;
   logic signed [31:0] rsp_new_vel_a_x, rsp_new_vel_a_y, rsp_new_vel_b_x, rsp_new_vel_b_y;
   logic signed [31:0] rsp_total_impulse;
   logic               rsp_acted;

   distance_constraint_solver_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint       rest_len = 65536;
   bit           cable_on = 1'b0;
   longint       impulse_acc = 0;
   link_out_type solved_q[$];
   int           err_count = 0;
   bit           rx_quiet = 1'b0;
   bit           rx_hold = 1'b0;
   bit           tx_quiet = 1'b0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qm(longint a, longint b);
      return clamp32((a * b) / 65536);
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_part(longint d, longint len);
      longint q;
      if (len <= 0) return 0;
      q = ((d < 0 ? -d : d) * 65536) / len;
      return d < 0 ? -q : q;
   endfunction

   function automatic link_out_type solve_link(link_item_type it);
      link_out_type o;
      longint pax, pay, pbx, pby, vax, vay, vbx, vby, ima, imb;
      longint dx, dy, len, err, dirx, diry, eff, rvx, rvy, jv, lam, px, py, ex, ey, msum;
      longint unsigned sq;
      pax = it.pax; pay = it.pay; pbx = it.pbx; pby = it.pby;
      vax = it.vax; vay = it.vay; vbx = it.vbx; vby = it.vby;
      ima = it.ima; imb = it.imb;
      dx = clamp32(pbx - pax);
      dy = clamp32(pby - pay);
      sq = longint'(dx * dx) + longint'(dy * dy);
      len = clamp32(longint'(root64(sq)));
      err = clamp32(len - rest_len);
      o.pax = it.pax; o.pay = it.pay; o.pbx = it.pbx; o.pby = it.pby;
      o.vax = it.vax; o.vay = it.vay; o.vbx = it.vbx; o.vby = it.vby;
      o.imp = impulse_acc[31:0];
      o.acted = 1'b0;
      if (cable_on && err <= 0) return o;
      dirx = unit_part(dx, len);
      diry = unit_part(dy, len);
      msum = ima + imb;
      eff = (msum != 0) ? clamp32(64'sh1_0000_0000 / msum) : 0;
      rvx = clamp32(vbx - vax);
      rvy = clamp32(vby - vay);
      jv = clamp32((dirx * rvx + diry * rvy) / 65536);
      lam = qm(eff, -jv);
      impulse_acc = clamp32(impulse_acc + lam);
      px = qm(dirx, lam);
      py = qm(diry, lam);
      o.vax = clamp32(vax - qm(px, ima));
      o.vay = clamp32(vay - qm(py, ima));
      o.vbx = clamp32(vbx + qm(px, imb));
      o.vby = clamp32(vby + qm(py, imb));
      ex = qm(qm(-dirx, err), eff);
      ey = qm(qm(-diry, err), eff);
      o.pax = clamp32(pax - qm(ex, ima));
      o.pay = clamp32(pay - qm(ey, ima));
      o.pbx = clamp32(pbx + qm(ex, imb));
      o.pby = clamp32(pby + qm(ey, imb));
      o.imp = impulse_acc[31:0];
      o.acted = 1'b1;
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      err_count++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // compare every result transfer with the oldest solved link
   always @(posedge clock) begin
      link_out_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (solved_q.size() == 0) begin
            report("unexpected result", 0, 0);
         end else begin
            w = solved_q.pop_front();
            if (rsp_new_pos_a_x !== w.pax) report("new_pos_a_x", rsp_new_pos_a_x, w.pax);
            if (rsp_new_pos_a_y !== w.pay) report("new_pos_a_y", rsp_new_pos_a_y, w.pay);
            if (rsp_new_pos_b_x !== w.pbx) report("new_pos_b_x", rsp_new_pos_b_x, w.pbx);
            if (rsp_new_pos_b_y !== w.pby) report("new_pos_b_y", rsp_new_pos_b_y, w.pby);
            if (rsp_new_vel_a_x !== w.vax) report("new_vel_a_x", rsp_new_vel_a_x, w.vax);
            if (rsp_new_vel_a_y !== w.vay) report("new_vel_a_y", rsp_new_vel_a_y, w.vay);
            if (rsp_new_vel_b_x !== w.vbx) report("new_vel_b_x", rsp_new_vel_b_x, w.vbx);
            if (rsp_new_vel_b_y !== w.vby) report("new_vel_b_y", rsp_new_vel_b_y, w.vby);
            if (rsp_total_impulse !== w.imp) report("total_impulse", rsp_total_impulse, w.imp);
            if (rsp_acted !== w.acted) report("acted", rsp_acted, w.acted);
         end
      end
   end

   // receiver: random stall before each transfer, one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rsp_stall <= 1'b1;
            repeat (700) @(posedge clock);
            rx_hold = 1'b0;
         end
         n = rx_quiet ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // offer one link; returns at the edge that took it, valid still high
   task automatic send_link(link_item_type it);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_pos_a_x <= it.pax; req_pos_a_y <= it.pay;
      req_pos_b_x <= it.pbx; req_pos_b_y <= it.pby;
      req_vel_a_x <= it.vax; req_vel_a_y <= it.vay;
      req_vel_b_x <= it.vbx; req_vel_b_y <= it.vby;
      req_inv_mass_a <= it.ima; req_inv_mass_b <= it.imb;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      solved_q.push_back(solve_link(it));
   endtask

   // drop valid and wait until every result is back
   task automatic drain;
      req_valid <= 1'b0;
      while (solved_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(dcs_pkg::csr_index_type idx, logic [30:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == dcs_pkg::CSR_LINK_LENGTH) rest_len = data;
      else cable_on = data[0];
   endtask

   function automatic link_item_type mk(longint ax, ay, bx, by, vax, vay, vbx, vby, ma, mb);
      link_item_type it;
      it.pax = ax[31:0]; it.pay = ay[31:0]; it.pbx = bx[31:0]; it.pby = by[31:0];
      it.vax = vax[31:0]; it.vay = vay[31:0]; it.vbx = vbx[31:0]; it.vby = vby[31:0];
      it.ima = ma[30:0]; it.imb = mb[30:0];
      return it;
   endfunction

   function automatic logic signed [31:0] near_val();
      return $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
   endfunction

   function automatic logic [30:0] pick_mass();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 31'($urandom);
         default: return 31'($urandom_range(1, 32'h0004_0000));
      endcase
   endfunction

   function automatic link_item_type rand_link();
      link_item_type it;
      if ($urandom_range(0, 3) == 0) begin
         it = mk($signed($urandom), $signed($urandom), $signed($urandom), $signed($urandom),
                 $signed($urandom), $signed($urandom), $signed($urandom), $signed($urandom),
                 $urandom, $urandom);
      end else begin
         it.pax = near_val(); it.pay = near_val(); it.pbx = near_val(); it.pby = near_val();
         it.vax = near_val(); it.vay = near_val(); it.vbx = near_val(); it.vby = near_val();
         it.ima = pick_mass(); it.imb = pick_mass();
      end
      return it;
   endfunction

   localparam longint ONE = 65536;
   localparam longint PMAX = 64'sd2147483647;
   localparam longint PMIN = -64'sd2147483648;

   task automatic test_rod_defaults;
      send_link(mk(0, 0, 2*ONE, 0, ONE, 0, -ONE, 0, ONE, ONE));
      send_link(mk(ONE, ONE, ONE, ONE, 3*ONE, 0, 0, ONE, ONE, 2*ONE));   // coincident
      send_link(mk(0, 0, ONE/2, ONE, 0, ONE, ONE, 0, 0, 0));             // both static
      send_link(mk(0, 0, 0, 3*ONE, 0, 0, 0, 5*ONE, 0, ONE));
      drain();
   endtask

   task automatic test_extremes;
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'h7FFF_FFFF);
      send_link(mk(PMIN, PMIN, PMAX, PMAX, PMIN, PMAX, PMAX, PMIN, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      send_link(mk(PMAX, PMIN, PMIN, PMAX, PMAX, PMAX, PMIN, PMIN, 1, 0));
      send_link(mk(-1, -1, -1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF, 0));
      drain();
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'h0);
      send_link(mk(0, 0, 0, 0, PMAX, PMAX, PMIN, PMIN, 1, 1));
      send_link(mk(PMAX, 0, PMIN, 0, PMIN, 0, PMAX, 0, 1, 0));
      send_link(mk(0, PMAX, 0, PMIN, 0, 0, 0, 0, ONE, ONE));
      drain();
   endtask

   task automatic test_cable;
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'(2*ONE));
      write_csr(dcs_pkg::CSR_CABLE_MODE, 31'd1);
      send_link(mk(0, 0, ONE, 0, ONE, 0, 0, 0, ONE, ONE));        // slack
      send_link(mk(0, 0, 2*ONE, 0, ONE, 0, 0, 0, ONE, ONE));      // exactly at length
      send_link(mk(0, 0, 3*ONE, ONE, ONE, 0, -ONE, 0, ONE, ONE)); // stretched
      send_link(mk(0, 0, 5*ONE, 0, 0, 0, 0, 0, 0, 0));            // stretched, static
      send_link(mk(ONE, ONE, ONE, ONE, 0, 0, 0, 0, ONE, ONE));    // coincident, slack
      drain();
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'h0);
      send_link(mk(ONE, ONE, ONE, ONE, 0, ONE, 0, 0, ONE, ONE));  // zero length, zero rest
      drain();
   endtask

   task automatic random_phase(int count);
      repeat (count) send_link(rand_link());
      drain();
   endtask

   task automatic test_random;
      write_csr(dcs_pkg::CSR_CABLE_MODE, 31'd0);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'(ONE));
      random_phase(110);
      write_csr(dcs_pkg::CSR_CABLE_MODE, 31'd1);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'(3*ONE));
      random_phase(110);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'($urandom));
      random_phase(60);
      write_csr(dcs_pkg::CSR_CABLE_MODE, 31'd0);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'h7FFF_FFFF);
      random_phase(60);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'h0);
      random_phase(60);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'($urandom_range(0, 32'h0008_0000)));
      write_csr(dcs_pkg::CSR_CABLE_MODE, 31'd1);
      random_phase(60);
   endtask

   // back to back with no idling, then a long receiver hold-off while links keep coming
   task automatic test_backpressure;
      write_csr(dcs_pkg::CSR_CABLE_MODE, 31'd0);
      write_csr(dcs_pkg::CSR_LINK_LENGTH, 31'(2*ONE));
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      repeat (30) send_link(rand_link());
      rx_quiet = 1'b0;
      rx_hold = 1'b1;
      repeat (20) send_link(rand_link());
      tx_quiet = 1'b0;
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rod_defaults();
      test_extremes();
      test_cable();
      test_random();
      test_backpressure();
      repeat (250) @(posedge clock);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #9ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/dcs_pkg.sv
rtl/core/distance_constraint_solver_top.sv
bench/distance_constraint_solver_top_test.sv
